// ----- src/ned_pkg.sv -----
// Package: shared types, codes and the byte classifier for the edit distance block.
package ned_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned SYM_W       = 6;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned SIM_W       = 16;

  localparam logic [SYM_W-1:0] SYM_SPACE = 6'd0;

  typedef enum logic [1:0] {
    KIND_KEEP  = 2'd0,
    KIND_WHITE = 2'd1,
    KIND_DROP  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [SYM_W-1:0] sym;
  } cls_t;

  typedef struct packed {
    logic accept;
    logic q_push;
    logic ovf;
    logic init_step;
    logic row_start;
    logic row_head;
    logic row_run;
    logic row_done;
    logic rd_dist;
    logic div_load;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic last;
    logic init;
    logic has_push;
    logic full;
    logic at_end;
    logic qc_zero;
    logic div_last;
  } sts_t;

  // Leet/symbol folding, lowercase, then symbol code or class.
  function automatic cls_t ned_classify(input logic [7:0] b);
    logic [7:0] c;
    cls_t       r;
    c = b;
    case (b)
      8'h30:   c = 8'h6F; // 0 -> o
      8'h31:   c = 8'h6C; // 1 -> l
      8'h33:   c = 8'h65; // 3 -> e
      8'h34:   c = 8'h61; // 4 -> a
      8'h35:   c = 8'h73; // 5 -> s
      8'h37:   c = 8'h74; // 7 -> t
      8'h40:   c = 8'h61; // @ -> a
      8'h24:   c = 8'h73; // $ -> s
      default: c = b;
    endcase
    if (c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
    r.sym  = SYM_SPACE;
    r.kind = KIND_DROP;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r.kind = KIND_KEEP;
      r.sym  = SYM_W'(c - 8'd96);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.kind = KIND_KEEP;
      r.sym  = SYM_W'(c - 8'd21);
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      r.kind = KIND_WHITE;
    end
    return r;
  endfunction

endpackage

// ----- src/ned_ctrl.sv -----
// Controller: sequences normalization pushes, row sweeps, division and result output.
module ned_ctrl import ned_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE     = 13'h0001,
    ST_DISPATCH = 13'h0002,
    ST_INIT     = 13'h0004,
    ST_NEXT     = 13'h0008,
    ST_QPUSH    = 13'h0010,
    ST_CPUSH    = 13'h0020,
    ST_ROW_HEAD = 13'h0040,
    ST_ROW_RUN  = 13'h0080,
    ST_ROW_DONE = 13'h0100,
    ST_RD_DIST  = 13'h0200,
    ST_DIV_LOAD = 13'h0400,
    ST_DIV      = 13'h0800,
    ST_EMIT     = 13'h1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = (sts_i.mode && sts_i.init) ? ST_INIT : ST_NEXT;
      end
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.at_end) state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (sts_i.has_push) state_d = sts_i.mode ? ST_CPUSH : ST_QPUSH;
        else if (sts_i.mode && sts_i.last) state_d = ST_RD_DIST;
        else state_d = ST_IDLE;
      end
      ST_QPUSH: begin
        if (sts_i.full) cmd_o.ovf = 1'b1;
        else cmd_o.q_push = 1'b1;
        state_d = ST_NEXT;
      end
      ST_CPUSH: begin
        if (sts_i.full) begin
          cmd_o.ovf = 1'b1;
          state_d   = ST_NEXT;
        end else begin
          cmd_o.row_start = 1'b1;
          state_d         = ST_ROW_HEAD;
        end
      end
      ST_ROW_HEAD: begin
        cmd_o.row_head = 1'b1;
        state_d        = sts_i.qc_zero ? ST_ROW_DONE : ST_ROW_RUN;
      end
      ST_ROW_RUN: begin
        cmd_o.row_run = 1'b1;
        if (sts_i.at_end) state_d = ST_ROW_DONE;
      end
      ST_ROW_DONE: begin
        cmd_o.row_done = 1'b1;
        state_d        = ST_NEXT;
      end
      ST_RD_DIST: begin
        cmd_o.rd_dist = 1'b1;
        state_d       = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/ned_dp.sv -----
// Datapath: normalization state, query and row memories, row update, divider, result regs.
module ned_dp import ned_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mode_i,
  input  logic [7:0]        char_byte_i,
  input  logic              last_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [LEN_W-1:0]  distance_o,
  output logic [LEN_W-1:0]  query_length_o,
  output logic [LEN_W-1:0]  content_length_o,
  output logic [SIM_W-1:0]  similarity_q16_o,
  output logic              empty_flag_o,
  output logic              overflow_flag_o
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned QW = $clog2(MAX_LEN);
  localparam int unsigned NW = CW + SIM_W;
  localparam int unsigned DCW = $clog2(NW);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

  logic [SYM_W-1:0] query_mem [MAX_LEN];
  logic [CW-1:0]    row_mem   [MAX_LEN+1];

  logic [CW-1:0]    qc_q, cc_q, j_q, diag_q, left_q, row_rd_q, dist_q, maxlen_q;
  logic             qsp_q, csp_q, qcomp_q, lov_q, cov_q;
  logic             mode_q, last_q, init_q, nsp_q, nsym_q, empty_q;
  logic [SYM_W-1:0] sym_q, q_rd_q;
  logic [CW-1:0]    rem_q;
  logic [NW-1:0]    nq_q;
  logic [DCW-1:0]   dcnt_q;

  logic [LEN_W-1:0] dist_out_q, ql_out_q, cl_out_q;
  logic [SIM_W-1:0] sim_out_q;
  logic             empty_out_q, ovf_out_q;

  cls_t             cls;
  logic             keep, white;
  logic [SYM_W-1:0] push_sym;
  logic             cost;
  logic [CW:0]      up1, left1, diag1, vmin;
  logic [CW-1:0]    v;
  logic             row_we, row_re, q_re;
  logic [CW-1:0]    row_wa, row_wd, row_ra;
  logic [QW-1:0]    q_ra;
  logic [CW:0]      trial;
  logic             qbit;
  logic [CW-1:0]    ml, diff;
  logic             emp;

  assign cls      = ned_classify(char_byte_i);
  assign keep     = (cls.kind == KIND_KEEP);
  assign white    = (cls.kind == KIND_WHITE);
  assign push_sym = nsp_q ? SYM_SPACE : sym_q;

  // one Levenshtein cell: min(up+1, left+1, diag+cost)
  assign cost  = (q_rd_q != push_sym);
  assign up1   = {1'b0, row_rd_q} + 1'b1;
  assign left1 = {1'b0, left_q} + 1'b1;
  assign diag1 = {1'b0, diag_q} + {{CW{1'b0}}, cost};
  always_comb begin
    vmin = up1;
    if (left1 < vmin) vmin = left1;
    if (diag1 < vmin) vmin = diag1;
  end
  assign v = vmin[CW-1:0];

  always_comb begin
    row_we = 1'b0;
    row_wa = j_q;
    row_wd = j_q;
    if (cmd_i.init_step) begin
      row_we = 1'b1;
    end else if (cmd_i.row_head) begin
      row_we = 1'b1;
      row_wa = '0;
      row_wd = cc_q + 1'b1;
    end else if (cmd_i.row_run) begin
      row_we = 1'b1;
      row_wd = v;
    end
  end

  always_comb begin
    row_re = 1'b0;
    row_ra = '0;
    q_re   = 1'b0;
    q_ra   = '0;
    if (cmd_i.row_start) begin
      row_re = 1'b1;
    end else if (cmd_i.row_head && qc_q != '0) begin
      row_re = 1'b1;
      row_ra = CW'(1);
      q_re   = 1'b1;
    end else if (cmd_i.row_run && j_q != qc_q) begin
      row_re = 1'b1;
      row_ra = j_q + 1'b1;
      q_re   = 1'b1;
      q_ra   = j_q[QW-1:0];
    end else if (cmd_i.rd_dist) begin
      row_re = 1'b1;
      row_ra = qc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    if (row_re) row_rd_q <= row_mem[row_ra];
    if (cmd_i.q_push) query_mem[qc_q[QW-1:0]] <= push_sym;
    if (q_re) q_rd_q <= query_mem[q_ra];
  end

  // divider step
  assign trial = {rem_q, nq_q[NW-1]};
  assign qbit  = (trial >= {1'b0, maxlen_q});

  assign ml   = (qc_q > cc_q) ? qc_q : cc_q;
  assign emp  = (qc_q == '0) || (cc_q == '0);
  assign diff = (emp || row_rd_q > ml) ? '0 : ml - row_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q    <= '0;
      cc_q    <= '0;
      qsp_q   <= 1'b0;
      csp_q   <= 1'b0;
      qcomp_q <= 1'b0;
      lov_q   <= 1'b0;
      cov_q   <= 1'b0;
      mode_q  <= 1'b0;
      last_q  <= 1'b0;
      init_q  <= 1'b0;
      nsp_q   <= 1'b0;
      nsym_q  <= 1'b0;
      j_q     <= '0;
      dcnt_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        mode_q <= mode_i;
        last_q <= last_i;
        j_q    <= '0;
        nsym_q <= keep;
        if (!mode_i) begin
          cc_q    <= '0;
          csp_q   <= 1'b0;
          cov_q   <= 1'b0;
          qcomp_q <= last_i;
          init_q  <= 1'b0;
          if (qcomp_q) begin
            qc_q  <= '0;
            lov_q <= 1'b0;
          end
          nsp_q <= keep && qsp_q && !qcomp_q;
          if (white) qsp_q <= 1'b1;
          else if (keep || qcomp_q) qsp_q <= 1'b0;
        end else begin
          qcomp_q <= 1'b1;
          init_q  <= (cc_q == '0);
          nsp_q   <= keep && csp_q;
          if (white) csp_q <= 1'b1;
          else if (keep) csp_q <= 1'b0;
        end
      end
      if (cmd_i.q_push || cmd_i.ovf || cmd_i.row_done) begin
        if (nsp_q) nsp_q <= 1'b0;
        else nsym_q <= 1'b0;
      end
      if (cmd_i.q_push) qc_q <= qc_q + 1'b1;
      if (cmd_i.ovf) begin
        if (mode_q) cov_q <= 1'b1;
        else lov_q <= 1'b1;
      end
      if (cmd_i.row_done) cc_q <= cc_q + 1'b1;
      if (cmd_i.init_step) j_q <= j_q + 1'b1;
      if (cmd_i.row_head) j_q <= CW'(1);
      if (cmd_i.row_run) j_q <= j_q + 1'b1;
      if (cmd_i.div_load) dcnt_q <= '0;
      if (cmd_i.div_step) dcnt_q <= dcnt_q + 1'b1;
      if (cmd_i.emit) begin
        cc_q  <= '0;
        csp_q <= 1'b0;
        cov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_head) begin
      diag_q <= row_rd_q;
      left_q <= cc_q + 1'b1;
    end
    if (cmd_i.row_run) begin
      diag_q <= row_rd_q;
      left_q <= v;
    end
    if (cmd_i.accept) sym_q <= cls.sym;
    if (cmd_i.div_load) begin
      dist_q   <= row_rd_q;
      maxlen_q <= ml;
      empty_q  <= emp;
      rem_q    <= '0;
      // 65535 * diff
      nq_q     <= {diff, {SIM_W{1'b0}}} - NW'(diff);
    end
    if (cmd_i.div_step) begin
      rem_q <= qbit ? CW'(trial - {1'b0, maxlen_q}) : trial[CW-1:0];
      nq_q  <= {nq_q[NW-2:0], qbit};
    end
    if (cmd_i.emit) begin
      dist_out_q  <= LEN_W'(dist_q);
      ql_out_q    <= LEN_W'(qc_q);
      cl_out_q    <= LEN_W'(cc_q);
      sim_out_q   <= empty_q ? '0 : nq_q[SIM_W-1:0];
      empty_out_q <= empty_q;
      ovf_out_q   <= lov_q || cov_q;
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.last     = last_q;
  assign sts_o.init     = init_q;
  assign sts_o.has_push = nsp_q || nsym_q;
  assign sts_o.full     = mode_q ? (cc_q == MAX_C) : (qc_q == MAX_C);
  assign sts_o.at_end   = (j_q == qc_q);
  assign sts_o.qc_zero  = (qc_q == '0);
  assign sts_o.div_last = (dcnt_q == DCW'(NW - 1));

  assign distance_o       = dist_out_q;
  assign query_length_o   = ql_out_q;
  assign content_length_o = cl_out_q;
  assign similarity_q16_o = sim_out_q;
  assign empty_flag_o     = empty_out_q;
  assign overflow_flag_o  = ovf_out_q;

endmodule

// ----- src/normalized_edit_distance_similarity.sv -----
// Top level: normalized edit distance similarity between a query and content strings.
//
//   channel | direction | handshake                 | fields
//   in      | input     | in_valid_i / in_stall_o   | mode_i, char_byte_i, last_i
//   out     | output    | out_valid_o / out_stall_i | distance_o .. overflow_flag_o
//
// Query word: stalls the next accept while it stores a symbol and any pending space before it.
// Content word: seeds the row while the content is still empty, then sweeps the row
// once per stored symbol (up to two), one cell per cycle; a symbol dropped on overflow
// is not swept.
// Closing word: adds a run of the serial divider, and waits while the previous output
// word is still stalled.
// rst_ni clears control and counters; memories are never cleared.
// A stalled output word holds; the next input word is still taken meanwhile.
module normalized_edit_distance_similarity import ned_pkg::*; #(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             mode_i,
  input  logic [7:0]       char_byte_i,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [LEN_W-1:0] distance_o,
  output logic [LEN_W-1:0] query_length_o,
  output logic [LEN_W-1:0] content_length_o,
  output logic [SIM_W-1:0] similarity_q16_o,
  output logic             empty_flag_o,
  output logic             overflow_flag_o
);

  cmd_t cmd;
  sts_t sts;

  ned_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ned_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_i),
    .char_byte_i      (char_byte_i),
    .last_i           (last_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .distance_o       (distance_o),
    .query_length_o   (query_length_o),
    .content_length_o (content_length_o),
    .similarity_q16_o (similarity_q16_o),
    .empty_flag_o     (empty_flag_o),
    .overflow_flag_o  (overflow_flag_o)
  );

endmodule

// ----- src/ned_chk.sv -----
// Checker: port-level properties of the edit distance block, bound to the top level.
module ned_chk import ned_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             mode_i,
  input logic             last_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [LEN_W-1:0] distance_o,
  input logic [LEN_W-1:0] query_length_o,
  input logic [LEN_W-1:0] content_length_o,
  input logic [SIM_W-1:0] similarity_q16_o
,
  input logic             empty_flag_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o)
      && $stable(similarity_q16_o))
    else $error("stalled output word changed");

  a_empty_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_flag_o |-> similarity_q16_o == '0)
    else $error("empty string with nonzero similarity");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_o <= query_length_o || distance_o <= content_length_o)
    else $error("distance above both lengths");

  a_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !empty_flag_o && distance_o == '0 |-> similarity_q16_o == 16'hFFFF)
    else $error("equal strings without full similarity");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i && last_i |=> in_stall_o)
    else $error("content end word did not start work");

endmodule

bind normalized_edit_distance_similarity ned_chk u_ned_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .mode_i           (mode_i),
  .last_i           (last_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .distance_o       (distance_o),
  .query_length_o   (query_length_o),
  .content_length_o (content_length_o),
  .similarity_q16_o (similarity_q16_o),
  .empty_flag_o     (empty_flag_o)
);

// ----- dv/tb_top.sv -----
// Testbench for the normalized edit distance similarity block.
`timescale 1ns / 100ps

module tb_top;
  import ned_pkg::*;

  localparam int unsigned QMAX = MAX_LEN_DEF;

  typedef struct packed {
    logic       mode;
    logic [7:0] chr;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [LEN_W-1:0] dst;
    logic [LEN_W-1:0] qlen;
    logic [LEN_W-1:0] clen;
    logic [SIM_W-1:0] sim;
    logic             empty;
    logic             ovf;
  } score_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             mode_i = 1'b0;
  logic [7:0]       char_byte_i = 8'd0;
  logic             last_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [LEN_W-1:0] distance_o;
  logic [LEN_W-1:0] query_length_o;
  logic [LEN_W-1:0] content_length_o;
  logic [SIM_W-1:0] similarity_q16_o;
  logic             empty_flag_o;
  logic             overflow_flag_o;

  normalized_edit_distance_similarity DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [SYM_W-1:0] q_sym [QMAX];
  int unsigned      row [QMAX+1];
  int unsigned      q_cnt, c_cnt;
  bit               q_sp, c_sp, q_done, q_ovf, c_ovf;

  word_t  pending_words[$];
  score_t expected_scores[$];
  int     errors = 0;
  int     send_idle_pct = 0, recv_stall_pct = 0;
  bit     hold_recv = 1'b0, drain_wait = 1'b0;
  bit     hold_go = 1'b0;
  bit     in_taken = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task automatic enqueue(input word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  function automatic void q_push(input logic [SYM_W-1:0] s);
    if (q_cnt >= QMAX) q_ovf = 1;
    else begin
      q_sym[q_cnt] = s;
      q_cnt++;
    end
  endfunction

  function automatic void c_push(input logic [SYM_W-1:0] s);
    int unsigned diag, up, v, cost;
    if (c_cnt >= QMAX) begin
      c_ovf = 1;
      return;
    end
    diag = row[0];
    row[0] = c_cnt + 1;
    for (int j = 1; j <= q_cnt; j++) begin
      up = row[j];
      cost = (q_sym[j-1] != s);
      v = up + 1;
      if (row[j-1] + 1 < v) v = row[j-1] + 1;
      if (diag + cost < v) v = diag + cost;
      diag = up;
      row[j] = v;
    end
    c_cnt++;
  endfunction

  // Updates the predictor for one accepted word; queues the expected score on a closing content word.
  function automatic void score_word(input word_t w);
    logic [7:0]  c;
    int          kind;
    logic [5:0]  s;
    int unsigned mx;
    score_t      r;
    c = w.chr;
    case (c)
      "0": c = "o";
      "1": c = "l";
      "3": c = "e";
      "4": c = "a";
      "5": c = "s";
      "7": c = "t";
      "@": c = "a";
      "$": c = "s";
      default: ;
    endcase
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    kind = 2;
    s = '0;
    if (c >= "a" && c <= "z") begin
      kind = 0;
      s = 6'(c - 8'd96);
    end else if (c >= "0" && c <= "9") begin
      kind = 0;
      s = 6'(c - 8'd21);
    end else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
      kind = 1;
    end
    if (!w.mode) begin
      if (q_done) begin
        q_cnt = 0;
        q_sp = 0;
        q_ovf = 0;
        q_done = 0;
      end
      c_cnt = 0;
      c_sp = 0;
      c_ovf = 0;
      if (kind == 1) q_sp = 1;
      else if (kind == 0) begin
        if (q_sp) begin
          q_sp = 0;
          q_push(SYM_SPACE);
        end
        q_push(s);
      end
      if (w.last) q_done = 1;
      return;
    end
    q_done = 1;
    if (c_cnt == 0)
      for (int j = 0; j <= q_cnt; j++) row[j] = j;
    if (kind == 1) c_sp = 1;
    else if (kind == 0) begin
      if (c_sp) begin
        c_sp = 0;
        c_push(SYM_SPACE);
      end
      c_push(s);
    end
    if (!w.last) return;
    mx = q_cnt > c_cnt ? q_cnt : c_cnt;
    r.dst = LEN_W'(row[q_cnt]);
    r.qlen = LEN_W'(q_cnt);
    r.clen = LEN_W'(c_cnt);
    r.empty = (q_cnt == 0) || (c_cnt == 0);
    r.sim = '0;
    if (!r.empty && row[q_cnt] <= mx)
      r.sim = SIM_W'((longint'(65535) * (mx - row[q_cnt])) / mx);
    r.ovf = q_ovf || c_ovf;
    expected_scores.insert(expected_scores.size(), r);
    c_cnt = 0;
    c_sp = 0;
    c_ovf = 0;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_words.size() != 0 && !drain_wait &&
          $urandom_range(99) >= send_idle_pct) begin
        word_t w;
        w = pending_words.pop_front();
        if ($isunknown(w.mode)) begin
          // marker: pause until every score is back
          drain_wait <= 1'b1;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          mode_i <= w.mode;
          char_byte_i <= w.chr;
          last_i <= w.last;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (drain_wait && expected_scores.size() == 0) drain_wait <= 1'b0;
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      score_word('{mode_i, char_byte_i, last_i});
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_scores.size() == 0) report("unexpected word", 1, 0);
      else begin
        score_t e;
        e = expected_scores.pop_front();
        if (distance_o !== e.dst) report("distance", distance_o, e.dst);
        if (query_length_o !== e.qlen) report("query_length", query_length_o, e.qlen);
        if (content_length_o !== e.clen) report("content_length", content_length_o, e.clen);
        if (similarity_q16_o !== e.sim) report("similarity", similarity_q16_o, e.sim);
        if (empty_flag_o !== e.empty) report("empty_flag", empty_flag_o, e.empty);
        if (overflow_flag_o !== e.ovf) report("overflow_flag", overflow_flag_o, e.ovf);
      end
    end
  end

  // long receiver hold, counted here while the sender keeps offering words
  initial begin
    wait (hold_go);
    hold_recv = 1'b1;
    repeat (2000) @(posedge clk_i);
    hold_recv = 1'b0;
  end

  function automatic logic [7:0] rand_char();
    int k;
    k = $urandom_range(99);
    if (k < 45) return 8'(8'h61 + $urandom_range(3));   // few letters: close matches
    if (k < 55) return 8'(8'h41 + $urandom_range(25));
    if (k < 70) return 8'(8'h30 + $urandom_range(9));
    if (k < 80) return 8'h20;
    if (k < 85) return 8'(8'h09 + $urandom_range(4));
    if (k < 90) return $urandom_range(1) ? 8'h40 : 8'h24;
    return 8'($urandom_range(255));
  endfunction

  task automatic add_string(input logic m, input int n);
    for (int i = 0; i < n; i++)
      enqueue('{m, rand_char(), i == n - 1});
  endtask

  task automatic add_text(input logic m, input string s);
    for (int i = 0; i < s.len(); i++)
      enqueue('{m, s[i], i == s.len() - 1});
  endtask

  function automatic int rand_len();
    return ($urandom_range(19) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 10);
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid_i || expected_scores.size() != 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    word_t marker;
    marker = '{1'bx, 8'd0, 1'b0};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty query, leet/case, whitespace runs, drops, overflow
    add_text(1'b1, "abc");
    add_text(1'b0, "H3ll0 W0rld");
    add_text(1'b1, "hello   world  ");
    add_text(1'b1, "\t@$!#\x7f\xff");
    add_text(1'b1, "  xyz");
    add_text(1'b0, "kitten");
    add_text(1'b1, "sitting");
    for (int i = 0; i < 70; i++) enqueue('{1'b0, 8'h7a, i == 69});
    for (int i = 0; i < 70; i++) enqueue('{1'b1, 8'h5a, i == 69});
    add_text(1'b1, "ab");
    enqueue('{1'b0, 8'h61, 1'b0}); // query byte, not last, starts a new query after this closed content
    add_text(1'b1, "qqq");
    add_text(1'b0, "a b");
    add_string(1'b1, 3);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 53 : 12) : 0;
      recv_stall_pct = (ph == 2) ? 53 : (ph == 3 ? 12 : 0);
      for (int q = 0; q < 8; q++) begin
        if ($urandom_range(9) == 0) add_string(1'($urandom_range(1)), 2); // noise
        add_string(1'b0, rand_len());
        for (int c = 0; c < 4; c++) begin
          int n;
          n = rand_len();
          if ($urandom_range(15) == 0) begin
            add_string(1'b1, n - 0);
            pending_words.delete(pending_words.size() - 1);
            enqueue('{1'b1, rand_char(), 1'b0}); // left open
          end else add_string(1'b1, n);
        end
      end
      if (ph == 0) begin
        enqueue(marker);
        add_string(1'b1, 4);
      end
      if (ph == 2) hold_go = 1'b1;
      wait_drained();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
src/ned_pkg.sv
src/ned_ctrl.sv
src/ned_dp.sv
src/normalized_edit_distance_similarity.sv
src/ned_chk.sv
dv/tb_top.sv
